@@ design/rfa_pkg.sv @@
`default_nettype none
package rfa_pkg;
   typedef enum logic [2:0] {
      OP_REDUCE = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_EQ     = 3'd5,
      OP_GT     = 3'd6,
      OP_LT     = 3'd7
   } opcode_type;

   // wide internal width: products of two 31-bit operands plus a carry
   localparam int unsigned WW = 64;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic setup;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

@@ design/rfa_ctrl.sv @@
`default_nettype none
module rfa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             out_free,
   input  wire rfa_pkg::sts_type sts,
   output logic                  busy,
   output rfa_pkg::cmd_type      cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_MUL1, S_MUL2, S_SETUP, S_GCD, S_DIVS, S_DIV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = sts.special ? S_DONE : S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) state_in = S_DIVS;
            else cmd.gcd_step = 1'b1;
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_DONE;
            else cmd.div_step = 1'b1;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

@@ design/rfa_dp.sv @@
`default_nettype none
module rfa_dp #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic [2:0]               opcode,
   input  wire logic [OPERAND_WIDTH-1:0] a_num,
   input  wire logic [OPERAND_WIDTH-1:0] a_den,
   input  wire logic [OPERAND_WIDTH-1:0] b_num,
   input  wire logic [OPERAND_WIDTH-1:0] b_den,
   input  wire rfa_pkg::cmd_type         cmd,
   output rfa_pkg::sts_type              sts,
   output logic [32:0]                   res_num,
   output logic [30:0]                   res_den,
   output logic                          cmp_true,
   output logic                          error
);
   localparam int unsigned W  = OPERAND_WIDTH;
   localparam int unsigned WW = rfa_pkg::WW;
   localparam int unsigned DW = 2 * W + 2;
   localparam int unsigned CW = $clog2(DW + 1);

   logic [2:0]        op_ff;
   logic signed [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [2*W-1:0] p1_ff, p2_ff, p3_ff;
   logic [WW-1:0]     x_ff, y_ff, g_ff, nm_ff, dm_ff, qn_ff, qd_ff, rn_ff, rd_ff;
   logic [6:0]        k_ff;
   logic [CW-1:0]     cnt_ff;
   logic              flip_ff, spec_ff;
   logic [32:0]       rnum_ff;
   logic [30:0]       rden_ff;
   logic              cmp_ff, err_ff;

   // one multiplier reused over the mul1 and mul2 product steps
   logic signed [W-1:0]   ma, mb;
   logic signed [2*W-1:0] prod;
   always_comb begin
      ma = an_ff; mb = bd_ff;
      if (cmd.mul1) begin
         ma = ad_ff; mb = bd_ff;
      end else if (cmd.mul2) begin
         ma = (op_ff == rfa_pkg::OP_MUL) ? an_ff : bn_ff;
         mb = ((op_ff == rfa_pkg::OP_MUL) || (op_ff == rfa_pkg::OP_DIV)) ? bn_ff : ad_ff;
         if (op_ff == rfa_pkg::OP_DIV) ma = ad_ff;
      end
      prod = ma * mb;
   end

   logic signed [WW-1:0] nx, dx, e1, e2, e3;
   always_comb begin
      e1 = WW'(p1_ff); e2 = WW'(p2_ff); e3 = WW'(p3_ff);
      // p1 = an*bd, p2 = ad*bd, p3 = bn*ad (an*bn for mul, ad*bn for div)
      unique case (rfa_pkg::opcode_type'(op_ff))
         rfa_pkg::OP_REDUCE: begin nx = WW'(an_ff); dx = WW'(ad_ff); end
         rfa_pkg::OP_ADD:    begin nx = e1 + e3; dx = e2; end
         rfa_pkg::OP_SUB:    begin nx = e1 - e3; dx = e2; end
         rfa_pkg::OP_MUL:    begin nx = e3; dx = e2; end
         rfa_pkg::OP_DIV:    begin nx = e1; dx = e3; end
         default:            begin nx = e1; dx = e3; end
      endcase
   end

   logic [WW-1:0] nmag, dmag;
   assign nmag = nx[WW-1] ? -nx : nx;
   assign dmag = dx[WW-1] ? -dx : dx;

   logic is_cmp, spec;
   assign is_cmp = (op_ff == rfa_pkg::OP_EQ) || (op_ff == rfa_pkg::OP_GT) ||
                   (op_ff == rfa_pkg::OP_LT);
   assign spec = is_cmp || (dx == '0) || (nx == '0) ||
                 ((op_ff == rfa_pkg::OP_DIV) && (bn_ff == '0));
   assign sts = '{special:  spec,
                  gcd_done: (y_ff == '0) || (x_ff == '0),
                  div_done: (cnt_ff == '0)};

   // binary gcd step
   logic [WW-1:0] gx, gy, gd;
   always_comb begin
      gx = x_ff; gy = y_ff; gd = '0;
      if (!x_ff[0] && !y_ff[0]) begin gx = x_ff >> 1; gy = y_ff >> 1; end
      else if (!x_ff[0]) gx = x_ff >> 1;
      else if (!y_ff[0]) gy = y_ff >> 1;
      else begin
         gd = (x_ff > y_ff) ? x_ff - y_ff : y_ff - x_ff;
         if (x_ff > y_ff) gx = gd >> 1; else gy = gd >> 1;
      end
   end
   logic [WW-1:0] gfin;
   assign gfin = (x_ff | y_ff) << k_ff;

   logic [WW-1:0] tn, td, sn, sd;
   assign tn = {rn_ff[WW-2:0], nm_ff[DW-1]};
   assign td = {rd_ff[WW-2:0], dm_ff[DW-1]};
   assign sn = tn - g_ff;
   assign sd = td - g_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode;
         an_ff <= a_num; ad_ff <= a_den; bn_ff <= b_num; bd_ff <= b_den;
         p1_ff <= $signed(a_num) * $signed(b_den);
      end
      if (cmd.mul1) p2_ff <= prod;
      if (cmd.mul2) p3_ff <= prod;
      if (cmd.setup) begin
         spec_ff <= spec;
         flip_ff <= nx[WW-1] ^ dx[WW-1];
         x_ff <= nmag; y_ff <= dmag; k_ff <= '0;
         nm_ff <= nmag; dm_ff <= dmag;
         cmp_ff <= 1'b0; err_ff <= 1'b0;
         rnum_ff <= '0; rden_ff <= 31'd1;
         if (op_ff == rfa_pkg::OP_EQ)
            cmp_ff <= (an_ff == bn_ff) && (ad_ff == bd_ff);
         else if (op_ff == rfa_pkg::OP_GT) cmp_ff <= $signed(e1) > $signed(e3);
         else if (op_ff == rfa_pkg::OP_LT) cmp_ff <= $signed(e1) < $signed(e3);
         else if ((dx == '0) || ((op_ff == rfa_pkg::OP_DIV) && (bn_ff == '0)))
            err_ff <= 1'b1;
      end
      if (cmd.gcd_step) begin
         x_ff <= gx; y_ff <= gy;
         if (!x_ff[0] && !y_ff[0]) k_ff <= k_ff + 7'd1;
      end
      if (cmd.div_start) begin
         g_ff <= gfin; rn_ff <= '0; rd_ff <= '0; qn_ff <= '0; qd_ff <= '0;
         cnt_ff <= CW'(DW);
      end
      if (cmd.div_step) begin
         nm_ff <= nm_ff << 1; dm_ff <= dm_ff << 1;
         cnt_ff <= cnt_ff - CW'(1);
         if (tn >= g_ff) begin rn_ff <= sn; qn_ff <= {qn_ff[WW-2:0], 1'b1}; end
         else begin rn_ff <= tn; qn_ff <= {qn_ff[WW-2:0], 1'b0}; end
         if (td >= g_ff) begin rd_ff <= sd; qd_ff <= {qd_ff[WW-2:0], 1'b1}; end
         else begin rd_ff <= td; qd_ff <= {qd_ff[WW-2:0], 1'b0}; end
      end
      if (cmd.finish) begin
         if (!spec_ff) begin
            rnum_ff <= flip_ff ? 33'(-qn_ff) : 33'(qn_ff);
            rden_ff <= 31'(qd_ff);
         end
      end
   end

   assign res_num  = rnum_ff;
   assign res_den  = rden_ff;
   assign cmp_true = cmp_ff;
   assign error    = err_ff;
endmodule
`default_nettype wire

@@ design/rational_fraction_alu_top.sv @@
`default_nettype none
// exact fraction alu: one result item per request item. an arithmetic item goes through
// the mul1 and mul2 multiplier steps, a binary gcd loop, and a restoring division of
// 2*OPERAND_WIDTH+2 steps sharing one subtractor pair; comparisons, zero results and
// error cases skip the gcd and division. a result not yet taken holds the last step.
// the result waits in an output register so the next item is taken while it is held
module rational_fraction_alu_top #(
   parameter int unsigned OPERAND_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // opcode, a_num, a_den, b_num, b_den from the lowest bit up
   input  wire logic [((3+4*OPERAND_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // res_num, res_den, cmp_true, error from the lowest bit up
   output logic [71:0]                       rsp_tdata
);
   localparam int unsigned W = OPERAND_WIDTH;

   rfa_pkg::cmd_type cmd;
   rfa_pkg::sts_type sts;
   logic busy, start, out_free;
   logic [32:0] res_num;
   logic [30:0] res_den;
   logic cmp_true, error;
   logic vld_ff;
   logic [71:0] data_ff;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   // result register is free when empty or being taken
   assign out_free   = !vld_ff || rsp_tready;

   rfa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .out_free(out_free),
      .sts(sts), .busy(busy), .cmd(cmd)
   );

   rfa_dp #(.OPERAND_WIDTH(W)) u_dp (
      .clock(clock),
      .opcode(req_tdata[2:0]),
      .a_num(req_tdata[3 +: W]),
      .a_den(req_tdata[3+W +: W]),
      .b_num(req_tdata[3+2*W +: W]),
      .b_den(req_tdata[3+3*W +: W]),
      .cmd(cmd), .sts(sts),
      .res_num(res_num), .res_den(res_den), .cmp_true(cmp_true), .error(error)
   );

   // the datapath result is updated in the same edge as finish, so it is
   // captured on the following edge through a pending flag
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.finish;
         if (pend_ff) begin
            vld_ff  <= 1'b1;
            data_ff <= {6'd0, error, cmp_true, res_den, res_num};
         end else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
endmodule
`default_nettype wire

@@ design/rfa_checker.sv @@
`default_nettype none
module rfa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:33] != 31'd0) else $error("zero denominator");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> rsp_tdata[32:0] == 33'd0) else $error("error value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("dropped item");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready while busy");
endmodule

bind rational_fraction_alu_top rfa_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb;
   localparam int OW = 16;
   localparam int REQ_W = ((3 + 4 * OW + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 20000;

   // one fraction result item
   typedef struct packed {
      logic        error;
      logic        cmp_true;
      logic [30:0] res_den;
      logic [32:0] res_num;
   } frac_result_type;

   // one directed row; has_exp marks rows whose answer is typed in
   typedef struct {
      rfa_pkg::opcode_type op;
      logic [15:0]         an, ad, bn, bd;
      bit                  has_exp;
      frac_result_type     exp;
   } stim_row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [71:0] rsp_tdata;

   frac_result_type pending_results[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  calm_rsp = 0;

   rational_fraction_alu_top #(.OPERAND_WIDTH(OW)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic frac_result_type make_result(longint n, longint d, bit c, bit e);
      frac_result_type r;
      r.res_num  = n[32:0];
      r.res_den  = d[30:0];
      r.cmp_true = c;
      r.error    = e;
      return r;
   endfunction

   // exact fraction arithmetic at 64 bits
   function automatic frac_result_type fraction_alu(rfa_pkg::opcode_type op,
         logic signed [15:0] a_n, logic signed [15:0] a_d, logic signed [15:0] b_n,
         logic signed [15:0] b_d);
      longint an, ad, bn, bd, n, d, g;
      an = a_n; ad = a_d; bn = b_n; bd = b_d;
      n = 0; d = 1;
      case (op)
         rfa_pkg::OP_REDUCE: begin n = an; d = ad; end
         rfa_pkg::OP_ADD:    begin n = an * bd + ad * bn; d = ad * bd; end
         rfa_pkg::OP_SUB:    begin n = an * bd - bn * ad; d = ad * bd; end
         rfa_pkg::OP_MUL:    begin n = an * bn; d = ad * bd; end
         rfa_pkg::OP_DIV: begin
            if (bn == 0) return make_result(0, 1, 0, 1);
            n = an * bd; d = ad * bn;
         end
         rfa_pkg::OP_EQ: return make_result(0, 1, (an == bn && ad == bd), 0);
         rfa_pkg::OP_GT: return make_result(0, 1, (an * bd > bn * ad), 0);
         default: return make_result(0, 1, (an * bd < bn * ad), 0);
      endcase
      // zero denominator anywhere in the product is an error
      if (d == 0) return make_result(0, 1, 0, 1);
      if (n == 0) return make_result(0, 1, 0, 0);
      g = euclid(magnitude(n), magnitude(d));
      n = n / g;
      d = d / g;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      return make_result(n, d, 0, 0);
   endfunction

   // send one item, queue its expectation, hold until accepted
   task automatic send_item(rfa_pkg::opcode_type op, logic [15:0] an, logic [15:0] ad,
         logic [15:0] bn, logic [15:0] bd, bit typed, frac_result_type typed_exp,
         bit calm);
      frac_result_type pred;
      pred = fraction_alu(op, an, ad, bn, bd);
      if (typed && pred !== typed_exp) begin
         $display("%0t table row mismatch: expected %h predicted %h", $time, typed_exp, pred);
         fail_count++;
      end
      // random gap before the item
      while (!calm && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - 3 - 4 * OW){1'b0}}, bd, bn, ad, an, op};
      pending_results.push_back(typed ? typed_exp : pred);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // random 16-bit value biased towards small and extreme magnitudes
   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom_range(65535);
         1: return 16'h8000 + $urandom_range(3) - 2;
         2: return 16'h7fff - $urandom_range(2);
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   // result side: random stalls, compare each accepted item
   always @(posedge clock) begin
      frac_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm_rsp || ($urandom_range(99) >= 20);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[65:0];
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result item: expected none actual %h", $time, got);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.res_num !== want.res_num) begin
                  $display("%0t res_num: expected %h actual %h", $time, want.res_num, got.res_num);
                  fail_count++;
               end
               if (got.res_den !== want.res_den) begin
                  $display("%0t res_den: expected %h actual %h", $time, want.res_den, got.res_den);
                  fail_count++;
               end
               if (got.cmp_true !== want.cmp_true) begin
                  $display("%0t cmp_true: expected %b actual %b", $time, want.cmp_true,
                           got.cmp_true);
                  fail_count++;
               end
               if (got.error !== want.error) begin
                  $display("%0t error: expected %b actual %b", $time, want.error, got.error);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog: cycles with no item accepted on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type table_rows[$];
      stim_row_type r;
      frac_result_type nothing;
      rfa_pkg::opcode_type op;
      logic [15:0] an, ad, bn, bd;
      int k, drain;
      nothing = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows: extremes, every opcode, error cases
      table_rows = '{
         '{rfa_pkg::OP_REDUCE, 16'd6, 16'd4, 16'd0, 16'd1, 1, make_result(3, 2, 0, 0)},
         '{rfa_pkg::OP_REDUCE, 16'd5, 16'd0, 16'd0, 16'd1, 1, make_result(0, 1, 0, 1)},
         '{rfa_pkg::OP_REDUCE, 16'd0, 16'hfff9, 16'd0, 16'd1, 1,
           make_result(0, 1, 0, 0)},
         '{rfa_pkg::OP_REDUCE, 16'd3, 16'hfffa, 16'd0, 16'd1, 1,
           make_result(-1, 2, 0, 0)},
         '{rfa_pkg::OP_REDUCE, 16'h8000, 16'h8000, 16'd0, 16'd1, 1,
           make_result(1, 1, 0, 0)},
         '{rfa_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1, make_result(5, 6, 0, 0)},
         '{rfa_pkg::OP_ADD, 16'h8000, 16'd1, 16'h8000, 16'd1, 1,
           make_result(-65536, 1, 0, 0)},
         '{rfa_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe, 0, nothing},
         '{rfa_pkg::OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1, make_result(0, 1, 0, 1)},
         '{rfa_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2, 1, make_result(0, 1, 0, 0)},
         '{rfa_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, nothing},
         '{rfa_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 0, nothing},
         '{rfa_pkg::OP_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 1,
           make_result(64'sd1073741824, 1, 0, 0)},
         '{rfa_pkg::OP_MUL, 16'd2, 16'd3, 16'd3, 16'd0, 1, make_result(0, 1, 0, 1)},
         '{rfa_pkg::OP_DIV, 16'd1, 16'd2, 16'd0, 16'd3, 1, make_result(0, 1, 0, 1)},
         '{rfa_pkg::OP_DIV, 16'd1, 16'd2, 16'hfffd, 16'd4, 1,
           make_result(-2, 3, 0, 0)},
         '{rfa_pkg::OP_DIV, 16'd1, 16'h8000, 16'h8000, 16'h7fff, 0, nothing},
         '{rfa_pkg::OP_EQ, 16'd1, 16'd2, 16'd1, 16'd2, 1, make_result(0, 1, 1, 0)},
         '{rfa_pkg::OP_EQ, 16'd1, 16'd2, 16'd2, 16'd4, 1, make_result(0, 1, 0, 0)},
         '{rfa_pkg::OP_GT, 16'd2, 16'd3, 16'd1, 16'd2, 1, make_result(0, 1, 1, 0)},
         '{rfa_pkg::OP_GT, 16'd1, 16'hffff, 16'd0, 16'd1, 1, make_result(0, 1, 1, 0)},
         '{rfa_pkg::OP_LT, 16'd1, 16'd3, 16'd1, 16'd2, 1, make_result(0, 1, 1, 0)},
         '{rfa_pkg::OP_LT, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, nothing}
      };
      foreach (table_rows[i]) begin
         r = table_rows[i];
         send_item(r.op, r.an, r.ad, r.bn, r.bd, r.has_exp, r.exp, 0);
      end

      // random items; a calm stretch in the middle with no idling
      for (k = 0; k < 1600; k++) begin
         calm_rsp = (k >= 600 && k < 800);
         op = rfa_pkg::opcode_type'($urandom_range(7));
         an = pick_value();
         ad = pick_value();
         bn = pick_value();
         bd = pick_value();
         // mostly well-formed positive denominators
         if ($urandom_range(99) < 80) begin
            if ($signed(ad) <= 0) ad = $urandom_range(32767, 1);
            if ($signed(bd) <= 0) bd = $urandom_range(32767, 1);
         end
         // equality needs matching fields to be true now and then
         if (op == rfa_pkg::OP_EQ && $urandom_range(1)) begin
            bn = an;
            bd = ad;
         end
         send_item(op, an, ad, bn, bd, 0, nothing, calm_rsp);
      end
      req_tvalid <= 1'b0;
      calm_rsp = 0;

      // drain, then a short grace period for stray items
      drain = 0;
      while (pending_results.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
design/rfa_pkg.sv
design/rfa_ctrl.sv
design/rfa_dp.sv
design/rational_fraction_alu_top.sv
design/rfa_checker.sv
bench/tb.sv
